[sv/zip_stored_entry_extractor_assert.svh]
// ----------------------------------------------------------------------------
// zip_stored_entry_extractor_assert.svh
// assertion macros shared by the header walker and queue modules
// ----------------------------------------------------------------------------
`ifndef ZIP_STORED_ENTRY_EXTRACTOR_ASSERT_SVH
`define ZIP_STORED_ENTRY_EXTRACTOR_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, sampled on clk, quiet in reset
`define ZSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zse assertion failed");
// next-cycle implication, sampled on clk, quiet in reset
`define ZSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zse assertion failed");
`else
`define ZSE_ASSERT_IMP(lbl, ante, cons)
`define ZSE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/zse_pkg.sv]
// ----------------------------------------------------------------------------
// zse_pkg
// types, constants and helpers for the zip stored entry extractor
// ----------------------------------------------------------------------------
package zse_pkg;

  localparam int NAME_BYTES_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [31:0] SIG_MAGIC = 32'h0403_4b50;

  localparam int          HDR_IDX_W     = 5;
  localparam logic [4:0]  SIG_BYTES     = 5'd4;
  localparam logic [4:0]  OFF_METHOD    = 5'd8;
  localparam logic [4:0]  OFF_SIZE      = 5'd18;
  localparam logic [4:0]  OFF_NAME_LEN  = 5'd26;
  localparam logic [4:0]  OFF_EXTRA_LEN = 5'd28;
  localparam logic [4:0]  HDR_LAST      = 5'd29;

  localparam int TLEN_W = 5;

  typedef enum logic [1:0] {
    REG_NAME_LEN   = 2'd0,
    REG_NAME_LOWER = 2'd1,
    REG_NAME_UPPER = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_PENDING     = 3'd0,
    ST_FOUND       = 3'd1,
    ST_BAD_SIG     = 3'd2,
    ST_NAME_TRUNC  = 3'd3,
    ST_COMPRESSED  = 3'd4,
    ST_DATA_TRUNC  = 3'd5,
    ST_NOT_FOUND   = 3'd6
  } status_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_NAME   = 5'b00010,
    PH_EXTRA  = 5'b00100,
    PH_SKIP   = 5'b01000,
    PH_EMIT   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       last_of_entry;
    logic [2:0] status;
  } result_t;

  function automatic result_t make_outcome(input status_t st);
    result_t r;
    r.kind          = 1'b1;
    r.payload_byte  = 8'd0;
    r.last_of_entry = 1'b0;
    r.status        = st;
    return r;
  endfunction

  function automatic result_t make_data(input logic [7:0] b, input logic last,
                                        input status_t st);
    result_t r;
    r.kind          = 1'b0;
    r.payload_byte  = b;
    r.last_of_entry = last;
    r.status        = st;
    return r;
  endfunction

endpackage

[sv/zse_in_if.sv]
// ----------------------------------------------------------------------------
// zse_in_if
// archive byte channel
// ----------------------------------------------------------------------------
interface zse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       end_of_file;

  modport source (output valid, output file_byte, output end_of_file, input ready);
  modport sink   (input valid, input file_byte, input end_of_file, output ready);
endinterface

[sv/zse_out_if.sv]
// ----------------------------------------------------------------------------
// zse_out_if
// result channel
// ----------------------------------------------------------------------------
interface zse_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic       last_of_entry;
  logic [2:0] status;

  modport source (output valid, output kind, output payload_byte,
                  output last_of_entry, output status, input ready);
  modport sink   (input valid, input kind, input payload_byte,
                  input last_of_entry, input status, output ready);
endinterface

[sv/zse_cfg_if.sv]
// ----------------------------------------------------------------------------
// zse_cfg_if
// register write channel
// ----------------------------------------------------------------------------
interface zse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/zse_front.sv]
// ----------------------------------------------------------------------------
// zse_front
// header walker: takes archive bytes, tracks the entry chain, emits words
// ----------------------------------------------------------------------------
module zse_front import zse_pkg::*; #(
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  zse_in_if.sink                      file_in,
  input  logic [TLEN_W-1:0]           tlen,
  input  logic [NAME_BYTES-1:0][7:0]  tname,
  input  logic                        q_full,
  output logic                        push,
  output result_t                     res
);

  `include "zip_stored_entry_extractor_assert.svh"

  localparam int IDX_W = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

  phase_t                 phase, phase_next;
  logic [HDR_IDX_W-1:0]   hdr_idx, hdr_idx_next;
  logic [31:0]            sig, sig_next;
  logic                   method_nz, method_nz_next;
  logic [31:0]            size, size_next;
  logic [15:0]            name_len, name_len_next;
  logic [15:0]            extra_len, extra_len_next;
  logic [31:0]            count, count_next;
  logic                   name_ok, name_ok_next;
  logic                   done, done_next;

  logic        accept, eof;
  logic [7:0]  b;
  logic [31:0] cnt_inc;
  logic        end_name, end_extra, m, byte_ok;

  assign file_in.ready = !q_full;
  assign accept        = file_in.valid && file_in.ready;
  assign b             = file_in.file_byte;
  assign eof           = file_in.end_of_file;
  assign cnt_inc       = count + 32'd1;

  always_comb begin
    phase_next     = phase;
    hdr_idx_next   = hdr_idx;
    sig_next       = sig;
    method_nz_next = method_nz;
    size_next      = size;
    name_len_next  = name_len;
    extra_len_next = extra_len;
    count_next     = count;
    name_ok_next   = name_ok;
    done_next      = done;
    push           = 1'b0;
    res            = '0;
    end_name       = 1'b0;
    end_extra      = 1'b0;
    m              = name_ok;
    byte_ok        = (count < 32'(tlen)) && (count < 32'(NAME_BYTES)) &&
                     (tname[count[IDX_W-1:0]] == b);

    if (accept && !done) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_idx < SIG_BYTES) sig_next = {b, sig[31:8]};
          case (hdr_idx)
            OFF_METHOD:          method_nz_next = (b != 8'd0);
            OFF_METHOD + 5'd1:   method_nz_next = method_nz || (b != 8'd0);
            OFF_SIZE:            size_next = {24'd0, b};
            OFF_SIZE + 5'd1:     size_next[15:8]  = b;
            OFF_SIZE + 5'd2:     size_next[23:16] = b;
            OFF_SIZE + 5'd3:     size_next[31:24] = b;
            OFF_NAME_LEN:        name_len_next = {8'd0, b};
            OFF_NAME_LEN + 5'd1: name_len_next[15:8] = b;
            OFF_EXTRA_LEN:       extra_len_next = {8'd0, b};
            HDR_LAST:            extra_len_next[15:8] = b;
            default: ;
          endcase
          if (hdr_idx == HDR_LAST) begin
            hdr_idx_next = '0;
            if (sig != SIG_MAGIC) begin
              push      = 1'b1;
              res       = make_outcome(ST_BAD_SIG);
              done_next = 1'b1;
            end else begin
              phase_next   = PH_NAME;
              count_next   = '0;
              name_ok_next = 1'b1;
              m            = 1'b1;
              if (name_len_next == 16'd0) end_name = 1'b1;
            end
          end else begin
            hdr_idx_next = hdr_idx + 5'd1;
          end
        end
        PH_NAME: begin
          if (!byte_ok) m = 1'b0;
          name_ok_next = m;
          count_next   = cnt_inc;
          if (cnt_inc == {16'd0, name_len}) end_name = 1'b1;
        end
        PH_EXTRA: begin
          count_next = cnt_inc;
          if (cnt_inc == {16'd0, extra_len}) end_extra = 1'b1;
        end
        PH_SKIP: begin
          count_next = cnt_inc;
          if (cnt_inc == size) begin
            phase_next   = PH_HEADER;
            hdr_idx_next = '0;
            count_next   = '0;
          end
        end
        PH_EMIT: begin
          push       = 1'b1;
          count_next = cnt_inc;
          if (cnt_inc == size) begin
            done_next = 1'b1;
            res       = make_data(b, 1'b1, ST_FOUND);
          end else begin
            res       = make_data(b, 1'b0, ST_PENDING);
          end
        end
        default: ;
      endcase

      if (end_name) begin
        if ((tlen > TLEN_W'(NAME_BYTES)) || ({11'd0, tlen} != name_len_next)) m = 1'b0;
        name_ok_next = m;
        count_next   = '0;
        if (extra_len_next != 16'd0) phase_next = PH_EXTRA;
        else                         end_extra  = 1'b1;
      end

      if (end_extra) begin
        count_next = '0;
        if (m) begin
          if (method_nz_next) begin
            push      = 1'b1;
            res       = make_outcome(ST_COMPRESSED);
            done_next = 1'b1;
          end else if (size_next == 32'd0) begin
            push      = 1'b1;
            res       = make_outcome(ST_FOUND);
            done_next = 1'b1;
          end else begin
            phase_next = PH_EMIT;
          end
        end else if (size_next != 32'd0) begin
          phase_next = PH_SKIP;
        end else begin
          phase_next   = PH_HEADER;
          hdr_idx_next = '0;
        end
      end
    end

    if (accept && eof) begin
      if (!done_next) begin
        push = 1'b1;
        if (phase_next == PH_NAME)
          res = make_outcome(ST_NAME_TRUNC);
        else if (phase_next == PH_EXTRA)
          res = make_outcome(!name_ok_next ? ST_NOT_FOUND :
                             (method_nz_next ? ST_COMPRESSED : ST_DATA_TRUNC));
        else if (phase_next == PH_EMIT)
          res = make_outcome(ST_DATA_TRUNC);
        else
          res = make_outcome(ST_NOT_FOUND);
      end
      phase_next     = PH_HEADER;
      hdr_idx_next   = '0;
      sig_next       = '0;
      method_nz_next = 1'b0;
      size_next      = '0;
      name_len_next  = '0;
      extra_len_next = '0;
      count_next     = '0;
      name_ok_next   = 1'b1;
      done_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      hdr_idx   <= '0;
      sig       <= '0;
      method_nz <= 1'b0;
      size      <= '0;
      name_len  <= '0;
      extra_len <= '0;
      count     <= '0;
      name_ok   <= 1'b1;
      done      <= 1'b0;
    end else begin
      phase     <= phase_next;
      hdr_idx   <= hdr_idx_next;
      sig       <= sig_next;
      method_nz <= method_nz_next;
      size      <= size_next;
      name_len  <= name_len_next;
      extra_len <= extra_len_next;
      count     <= count_next;
      name_ok   <= name_ok_next;
      done      <= done_next;
    end
  end

  `ZSE_ASSERT_IMP(a_data_only_in_emit, push && !res.kind, phase == PH_EMIT)
  `ZSE_ASSERT_NXT(a_rearm_after_eof, accept && eof, phase == PH_HEADER && !done && hdr_idx == '0)

endmodule

[sv/zse_queue.sv]
// ----------------------------------------------------------------------------
// zse_queue
// short word queue between the header walker and the output stage
// ----------------------------------------------------------------------------
module zse_queue import zse_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t wr_word,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output result_t rd_word
);

  `include "zip_stored_entry_extractor_assert.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   cnt;

  assign full      = (cnt == CNT_W'(DEPTH));
  assign not_empty = (cnt != '0);
  assign rd_word   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      cnt <= cnt + CNT_W'(1);
      else if (pop && !push) cnt <= cnt - CNT_W'(1);
    end
  end

  `ZSE_ASSERT_IMP(a_no_overflow, push, !full)
  `ZSE_ASSERT_IMP(a_no_underflow, pop, not_empty)

endmodule

[sv/zse_back.sv]
// ----------------------------------------------------------------------------
// zse_back
// output stage: registers queued words and drives the result channel
// ----------------------------------------------------------------------------
module zse_back import zse_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  result_t    q_word,
  output logic       pop,
  zse_out_if.source  result_out
);

  logic    ovalid;
  result_t oword;

  assign pop = q_valid && (!ovalid || result_out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (!ovalid || result_out.ready) begin
      ovalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) oword <= q_word;
  end

  assign result_out.valid         = ovalid;
  assign result_out.kind          = oword.kind;
  assign result_out.payload_byte  = oword.payload_byte;
  assign result_out.last_of_entry = oword.last_of_entry;
  assign result_out.status        = oword.status;

endmodule

[sv/zip_stored_entry_extractor.sv]
// ----------------------------------------------------------------------------
// zip_stored_entry_extractor
// walks zip local file headers and streams the bytes of one stored entry
//
//   channel      dir   word
//   cfg          in    index, data (name length, name bytes 0-7, 8-15)
//   file_in      in    file_byte, end_of_file
//   result_out   out   kind, payload_byte, last_of_entry, status
//
// one archive byte per cycle while the result queue is not full; a result word
// passes through the queue and then the output register after its byte is taken
// reset clears the registers, the walker and the queue; no clearing pass
// file_in.ready drops only while the result queue is full
// cfg.ready is always high
// ----------------------------------------------------------------------------
module zip_stored_entry_extractor import zse_pkg::*; #(
  parameter int NAME_BYTES  = NAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  zse_cfg_if.sink    cfg,
  zse_in_if.sink     file_in,
  zse_out_if.source  result_out
);

  logic [TLEN_W-1:0]          tlen;
  logic [NAME_BYTES-1:0][7:0] tname;

  logic    push, pop, q_full, q_valid;
  result_t f_word, q_word;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tlen  <= '0;
      tname <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_NAME_LEN: tlen <= cfg.data[TLEN_W-1:0];
        REG_NAME_LOWER: begin
          for (int k = 0; k < NAME_BYTES; k++) begin
            if (k < 8) tname[k] <= cfg.data[8*(k%8) +: 8];
          end
        end
        REG_NAME_UPPER: begin
          for (int k = 0; k < NAME_BYTES; k++) begin
            if (k >= 8) tname[k] <= cfg.data[8*(k%8) +: 8];
          end
        end
        default: ;
      endcase
    end
  end

  zse_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk     (clk),
    .rst     (rst),
    .file_in (file_in),
    .tlen    (tlen),
    .tname   (tname),
    .q_full  (q_full),
    .push    (push),
    .res     (f_word)
  );

  zse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_word   (f_word),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_word   (q_word)
  );

  zse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_word     (q_word),
    .pop        (pop),
    .result_out (result_out)
  );

endmodule

[sim/zip_stored_entry_extractor_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// zip_stored_entry_extractor_test
// Builds small zip archives byte by byte and streams them through the
// extractor with random gaps on the input and random stalls on the output.
// A local model of the header walker predicts every result word, which is
// checked field by field as it leaves the block. Directed archives cover the
// outcomes and name edge cases, followed by random archives under changing
// target names.
// ----------------------------------------------------------------------------
module zip_stored_entry_extractor_test;
  import zse_pkg::*;

  localparam int NAME_MAX    = NAME_BYTES_DEF;
  localparam int ITEMS       = 1650;
  localparam int CYCLE_LIMIT = 500000;

  logic clk;
  logic rst;

  zse_cfg_if cfg ();
  zse_in_if  file_in ();
  zse_out_if result_out ();

  zip_stored_entry_extractor dut (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .file_in    (file_in),
    .result_out (result_out)
  );

  // walker model state
  phase_t       walk_phase;
  logic [4:0]   hdr_idx;
  logic [31:0]  sig_shift;
  logic [15:0]  method_f;
  logic [31:0]  size_f;
  logic [15:0]  name_len_f;
  logic [15:0]  extra_len_f;
  logic [31:0]  phase_cnt;
  bit           name_ok;
  bit           done_f;
  logic [4:0]   want_len;
  logic [127:0] want_name;
  result_t      word_next;

  result_t pending_words[$];
  result_t seen_word;
  bit      quiet;
  int      cycle_count;
  int      fail_count;
  int      bytes_sent;
  int      archives_sent;
  int      words_checked;
  int      reg_writes;

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic void clear_walk();
    walk_phase  = PH_HEADER;
    hdr_idx     = '0;
    sig_shift   = '0;
    method_f    = '0;
    size_f      = '0;
    name_len_f  = '0;
    extra_len_f = '0;
    phase_cnt   = '0;
    name_ok     = 1'b1;
    done_f      = 1'b0;
  endfunction

  function automatic bit conclude(input status_t st);
    done_f                  = 1'b1;
    word_next.kind          = 1'b1;
    word_next.payload_byte  = 8'd0;
    word_next.last_of_entry = 1'b0;
    word_next.status        = st;
    return 1'b1;
  endfunction

  function automatic bit after_extra();
    phase_cnt = '0;
    if (name_ok) begin
      if (method_f != 16'd0) return conclude(ST_COMPRESSED);
      if (size_f == 32'd0) return conclude(ST_FOUND);
      walk_phase = PH_EMIT;
      return 1'b0;
    end
    if (size_f != 32'd0) begin
      walk_phase = PH_SKIP;
    end else begin
      walk_phase = PH_HEADER;
      hdr_idx    = '0;
    end
    return 1'b0;
  endfunction

  function automatic bit after_name();
    if (want_len > NAME_MAX || name_len_f != want_len) name_ok = 1'b0;
    phase_cnt = '0;
    if (extra_len_f != 16'd0) begin
      walk_phase = PH_EXTRA;
      return 1'b0;
    end
    return after_extra();
  endfunction

  // advances the walker by one archive byte; returns 1 when a word is due
  function automatic bit walk_byte(input logic [7:0] b, input bit eof);
    bit      got;
    status_t st;
    got = 1'b0;
    if (!done_f) begin
      case (walk_phase)
        PH_HEADER: begin
          if (hdr_idx < SIG_BYTES) sig_shift = {b, sig_shift[31:8]};
          else if (hdr_idx == OFF_METHOD) method_f = {8'd0, b};
          else if (hdr_idx == OFF_METHOD + 5'd1) method_f[15:8] = b;
          else if (hdr_idx >= OFF_SIZE && hdr_idx <= OFF_SIZE + 5'd3) begin
            if (hdr_idx == OFF_SIZE) size_f = '0;
            size_f[8*(hdr_idx-OFF_SIZE) +: 8] = b;
          end
          else if (hdr_idx == OFF_NAME_LEN) name_len_f = {8'd0, b};
          else if (hdr_idx == OFF_NAME_LEN + 5'd1) name_len_f[15:8] = b;
          else if (hdr_idx == OFF_EXTRA_LEN) extra_len_f = {8'd0, b};
          else if (hdr_idx == HDR_LAST) extra_len_f[15:8] = b;
          if (hdr_idx >= HDR_LAST) begin
            hdr_idx = '0;
            if (sig_shift != SIG_MAGIC) begin
              got = conclude(ST_BAD_SIG);
            end else begin
              walk_phase = PH_NAME;
              phase_cnt  = '0;
              name_ok    = 1'b1;
              if (name_len_f == 16'd0) got = after_name();
            end
          end else begin
            hdr_idx = hdr_idx + 5'd1;
          end
        end
        PH_NAME: begin
          if (phase_cnt >= want_len || phase_cnt >= NAME_MAX ||
              want_name[8*phase_cnt +: 8] != b) name_ok = 1'b0;
          phase_cnt = phase_cnt + 1;
          if (phase_cnt >= name_len_f) got = after_name();
        end
        PH_EXTRA: begin
          phase_cnt = phase_cnt + 1;
          if (phase_cnt >= extra_len_f) got = after_extra();
        end
        PH_SKIP: begin
          phase_cnt = phase_cnt + 1;
          if (phase_cnt >= size_f) begin
            walk_phase = PH_HEADER;
            hdr_idx    = '0;
            phase_cnt  = '0;
          end
        end
        default: begin
          phase_cnt              = phase_cnt + 1;
          word_next.kind         = 1'b0;
          word_next.payload_byte = b;
          if (phase_cnt >= size_f) begin
            done_f                  = 1'b1;
            word_next.last_of_entry = 1'b1;
            word_next.status        = ST_FOUND;
          end else begin
            word_next.last_of_entry = 1'b0;
            word_next.status        = ST_PENDING;
          end
          got = 1'b1;
        end
      endcase
    end
    if (eof) begin
      if (!done_f) begin
        if (walk_phase == PH_NAME) st = ST_NAME_TRUNC;
        else if (walk_phase == PH_EXTRA)
          st = name_ok ? (method_f != 16'd0 ? ST_COMPRESSED : ST_DATA_TRUNC) : ST_NOT_FOUND;
        else if (walk_phase == PH_EMIT) st = ST_DATA_TRUNC;
        else st = ST_NOT_FOUND;
        got = conclude(st);
      end
      clear_walk();
    end
    return got;
  endfunction

  // result word checker
  always @(posedge clk) begin
    if (!rst && result_out.valid && result_out.ready) begin
      words_checked <= words_checked + 1;
      if (pending_words.size() == 0) begin
        $error("result word with none expected: kind %0d byte %0d last %0d status %0d",
               result_out.kind, result_out.payload_byte, result_out.last_of_entry,
               result_out.status);
        fail_count++;
      end else begin
        seen_word = pending_words.pop_front();
        if (result_out.kind !== seen_word.kind) begin
          $error("kind mismatch: expected %0d, actual %0d", seen_word.kind, result_out.kind);
          fail_count++;
        end
        if (result_out.payload_byte !== seen_word.payload_byte) begin
          $error("payload_byte mismatch: expected %0d, actual %0d",
                 seen_word.payload_byte, result_out.payload_byte);
          fail_count++;
        end
        if (result_out.last_of_entry !== seen_word.last_of_entry) begin
          $error("last_of_entry mismatch: expected %0d, actual %0d",
                 seen_word.last_of_entry, result_out.last_of_entry);
          fail_count++;
        end
        if (result_out.status !== seen_word.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 seen_word.status, result_out.status);
          fail_count++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // output stalls
  initial begin
    int n;
    result_out.ready = 1'b0;
    forever begin
      result_out.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      n = pick_gap();
      if (n > 0) begin
        result_out.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit eof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      file_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    file_in.valid       <= 1'b1;
    file_in.file_byte   <= b;
    file_in.end_of_file <= eof;
    do @(posedge clk); while (!file_in.ready);
    if (walk_byte(b, eof)) pending_words.push_back(word_next);
    bytes_sent++;
  endtask

  task automatic send_archive(ref logic [7:0] arc[$]);
    for (int i = 0; i < arc.size(); i++) send_byte(arc[i], i == arc.size() - 1);
    archives_sent++;
  endtask

  // stop sending and let every expected word come out
  task automatic wait_idle();
    file_in.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_NAME_LEN:   want_len = v[4:0];
      REG_NAME_LOWER: want_name[63:0] = v;
      default:        want_name[127:64] = v;
    endcase
    reg_writes++;
  endtask

  task automatic set_target(input logic [4:0] len, input logic [127:0] nm);
    wait_idle();
    write_reg(REG_NAME_LEN, {59'd0, len});
    write_reg(REG_NAME_LOWER, nm[63:0]);
    write_reg(REG_NAME_UPPER, nm[127:64]);
    cfg.valid <= 1'b0;
  endtask

  // appends one local header with its name, extra field and payload
  function automatic void add_entry(ref logic [7:0] arc[$], input logic [31:0] sig,
                                    input logic [15:0] method, input logic [15:0] nlen,
                                    input logic [127:0] nm, input logic [15:0] xlen,
                                    input logic [31:0] csize, input int psize);
    for (int i = 0; i < 30; i++) begin
      if (i < 4) arc.push_back(sig[8*i +: 8]);
      else if (i == 8 || i == 9) arc.push_back(method[8*(i-8) +: 8]);
      else if (i >= 18 && i <= 21) arc.push_back(csize[8*(i-18) +: 8]);
      else if (i == 26 || i == 27) arc.push_back(nlen[8*(i-26) +: 8]);
      else if (i == 28 || i == 29) arc.push_back(xlen[8*(i-28) +: 8]);
      else arc.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < nlen; i++)
      arc.push_back(i < NAME_MAX ? nm[8*i +: 8] : 8'($urandom_range(0, 255)));
    repeat (xlen) arc.push_back(8'($urandom_range(0, 255)));
    repeat (psize) arc.push_back(8'($urandom_range(0, 255)));
  endfunction

  task automatic test_tiny_archives();
    logic [7:0] arc[$];
    arc.push_back(8'h00);
    send_archive(arc);
    arc = '{8'hff};
    send_archive(arc);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd0, '0, 16'd0, 32'd0, 0);
    void'(arc.pop_back());
    send_archive(arc);
  endtask

  task automatic test_stored_match();
    logic [7:0]   arc[$];
    logic [127:0] nm;
    nm = {$urandom, $urandom, $urandom, $urandom};
    set_target(5'd5, nm);
    // skipped entry, matched entry, then one that is ignored
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm ^ 128'h1, 16'd2, 32'd4, 4);
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd0, 32'd3, 3);
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd0, 32'd2, 2);
    send_archive(arc);
    // empty stored entry, trailing byte
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd0, 32'd0, 0);
    arc.push_back(8'h5a);
    send_archive(arc);
    // extra field before a one byte payload, after an empty skipped entry
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd6, nm, 16'd0, 32'd0, 0);
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd3, 32'd1, 1);
    send_archive(arc);
  endtask

  task automatic test_error_outcomes();
    logic [7:0]   arc[$];
    logic [127:0] nm;
    nm = want_name;
    add_entry(arc, SIG_MAGIC ^ 32'h100, 16'd0, 16'd5, nm, 16'd0, 32'd2, 2);
    send_archive(arc);
    // name cut short
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd0, 32'd2, 2);
    repeat (5) void'(arc.pop_back());
    send_archive(arc);
    // compressed match, with and without extra field
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd8, 16'd5, nm, 16'd0, 32'd3, 3);
    send_archive(arc);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'hffff, 16'd5, nm, 16'd2, 32'd3, 3);
    send_archive(arc);
    // end inside the extra field: stored match, compressed match, no match
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd4, 32'd3, 3);
    repeat (5) void'(arc.pop_back());
    send_archive(arc);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd8, 16'd5, nm, 16'd4, 32'd3, 3);
    repeat (5) void'(arc.pop_back());
    send_archive(arc);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd4, nm, 16'd4, 32'd3, 3);
    repeat (5) void'(arc.pop_back());
    send_archive(arc);
    // end inside a matched payload
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd5, nm, 16'd0, 32'd6, 6);
    repeat (3) void'(arc.pop_back());
    send_archive(arc);
  endtask

  task automatic test_name_extremes();
    logic [7:0]   arc[$];
    logic [127:0] nm;
    set_target(5'd0, '0);
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd0, '0, 16'd0, 32'd2, 2);
    send_archive(arc);
    set_target(5'd16, '1);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd16, '1, 16'd0, 32'd2, 2);
    send_archive(arc);
    nm = {$urandom, $urandom, $urandom, $urandom};
    set_target(5'd31, nm);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd31, nm, 16'd0, 32'd1, 1);
    send_archive(arc);
    set_target(5'd16, '0);
    arc.delete();
    add_entry(arc, SIG_MAGIC, 16'd0, 16'd16, '0, 16'd1, 32'd3, 3);
    send_archive(arc);
  endtask

  task automatic random_archive();
    logic [7:0]   arc[$];
    logic [127:0] nm;
    logic [31:0]  sig;
    logic [31:0]  csize;
    logic [15:0]  method;
    logic [15:0]  nlen;
    logic [15:0]  xlen;
    int           entries;
    int           m;
    int           pos;
    int           lim;
    int           psize;
    bit           huge;
    quiet = ($urandom_range(0, 99) < 20);
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(1, 40)) arc.push_back(8'($urandom_range(0, 255)));
    end else begin
      entries = $urandom_range(1, 3);
      for (int e = 0; e < entries; e++) begin
        sig    = ($urandom_range(0, 99) < 4) ? $urandom : SIG_MAGIC;
        m      = $urandom_range(0, 99);
        method = (m < 8) ? 16'd8 : (m < 12) ? 16'($urandom) : 16'd0;
        nlen   = 16'(want_len);
        nm     = want_name;
        lim    = (want_len < NAME_MAX) ? want_len : NAME_MAX;
        m      = $urandom_range(0, 99);
        if (m >= 40 && m < 60 && lim > 0) begin
          pos = $urandom_range(0, lim - 1);
          nm[8*pos +: 8] = nm[8*pos +: 8] ^ 8'($urandom_range(1, 255));
        end else if (m >= 60 && m < 75) begin
          nlen = (want_len == 0 || $urandom_range(0, 1)) ? 16'(want_len) + 16'd1 :
                 16'(want_len) - 16'd1;
        end else if (m >= 75) begin
          nlen = 16'($urandom_range(0, 18));
          nm   = {$urandom, $urandom, $urandom, $urandom};
        end
        m    = $urandom_range(0, 99);
        xlen = (m < 70) ? 16'd0 : (m < 98) ? 16'($urandom_range(1, 5)) :
               16'($urandom_range(30, 60));
        m     = $urandom_range(0, 99);
        psize = (m < 15) ? 0 : (m < 90) ? $urandom_range(1, 12) : $urandom_range(13, 48);
        huge  = ($urandom_range(0, 99) < 3);
        csize = huge ? $urandom : psize;
        if (huge) psize = $urandom_range(0, 20);
        add_entry(arc, sig, method, nlen, nm, xlen, csize, psize);
        if (huge) break;
      end
      if ($urandom_range(0, 99) < 10)
        repeat ($urandom_range(1, 10)) arc.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 15 && arc.size() > 1)
        repeat ($urandom_range(1, arc.size() - 1)) void'(arc.pop_back());
    end
    send_archive(arc);
  endtask

  task automatic test_random_archives();
    int           m;
    logic [4:0]   len;
    logic [127:0] nm;
    while (bytes_sent < ITEMS || words_checked < 60) begin
      if ($urandom_range(0, 99) < 25) begin
        m   = $urandom_range(0, 99);
        len = (m < 10) ? 5'd0 : (m < 20) ? 5'd16 : (m < 25) ? 5'($urandom_range(17, 31)) :
              5'($urandom_range(1, 15));
        m   = $urandom_range(0, 99);
        nm  = (m < 5) ? '0 : (m < 10) ? '1 : {$urandom, $urandom, $urandom, $urandom};
        set_target(len, nm);
      end
      random_archive();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst                 = 1'b1;
    cfg.valid           = 1'b0;
    cfg.index           = REG_NAME_LEN;
    cfg.data            = '0;
    file_in.valid       = 1'b0;
    file_in.file_byte   = '0;
    file_in.end_of_file = 1'b0;
    want_len            = '0;
    want_name           = '0;
    word_next           = '0;
    quiet               = 1'b0;
    cycle_count         = 0;
    fail_count          = 0;
    bytes_sent          = 0;
    archives_sent       = 0;
    words_checked       = 0;
    reg_writes          = 0;
    clear_walk();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_tiny_archives();
    test_stored_match();
    test_error_outcomes();
    test_name_extremes();
    test_random_archives();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("run covered %0d archive bytes in %0d archives, %0d result words checked",
             bytes_sent, archives_sent, words_checked);
    $display("target name rewritten through %0d register writes", reg_writes);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
